// ===== design/sinrs_pkg.sv =====
// Package for the sorted index node route split unit.
// Holds sizes, state machine, command and status types shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package sinrs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int ACT_W       = 2;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES - 2);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SPLIT  = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_ROOT   = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_SPL_SETUP,
    ST_SPL_MRD,
    ST_SPL_MTAKE,
    ST_SPL_RD,
    ST_SPL_EMIT,
    ST_LOC_CHK,
    ST_LOC_CMP,
    ST_LOC_END,
    ST_EMIT_OK,
    ST_EMIT_FULL,
    ST_EMIT_MID
  } state_t;

  typedef enum logic [1:0] {
    RD_POS_M1,
    RD_MID,
    RD_POS
  } rd_sel_t;

  typedef enum logic [2:0] {
    OUT_OK,
    OUT_FULL,
    OUT_MID,
    OUT_END,
    OUT_HIT,
    OUT_ENTRY
  } out_kind_t;

  typedef struct packed {
    logic      in_ready;
    logic      latch_in;
    logic      pos_count;
    logic      pos_clear;
    logic      pos_dec;
    logic      pos_inc;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_shift;
    logic      wr_new;
    logic      set_root;
    logic      split_setup;
    logic      take_mid;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic pos_zero;
    logic key_less;
    logic rd_ge;
    logic pos_ge_count;
    logic full;
    logic count_max;
    logic count_zero;
    logic mid_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/sorted_index_node_route_split_unit.sv =====
// Top level of the sorted index node route split unit: sinrs_ctrl and sinrs_dp, on sinrs_pkg.
// Insert shifts larger pairs up one at a time, then writes the new pair; a full node refuses.
// Locate scans from index 0 to the first key not below the probe, else gives the end page.
// Split inserts if room, then emits each entry above the middle, or just the middle key.
// One item at a time; the next transfer is taken the cycle after the last result loads. Output
// stalls add cycles. Reset (rst, synchronous) empties the node and drops any pending result.
`timescale 1ns / 1ps

module sorted_index_node_route_split_unit (
  input  logic          clk,
  input  logic          rst,
  // Input stream.
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // key [31:0], page [63:32], right_page [95:64]
  input  logic [1:0]    s_tuser,   // action [1:0]
  // Result stream.
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // moved_key, result_page, middle_key, entry_count, zero pad
  output logic [1:0]    m_tuser,   // status [0], has_entry [1]
  output logic          m_tlast
);

  sinrs_pkg::cmd_t cmd;
  sinrs_pkg::sts_t sts;

  logic                  out_status;
  logic                  out_has_entry;
  logic signed [31:0]    out_moved_key;
  logic signed [31:0]    out_result_page;
  logic signed [31:0]    out_middle_key;
  logic [sinrs_pkg::CNT_W-1:0] out_entry_count;

  // The controller sequences each action through the datapath; the input is
  // taken only while the controller is idle, and every result is placed into
  // the output register; loading an action's last result frees the controller for the next transfer.
  sinrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  sinrs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (s_tuser),
    .in_key          (s_tdata[31:0]),
    .in_page         (s_tdata[63:32]),
    .in_right_page   (s_tdata[95:64]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_status      (out_status),
    .out_has_entry   (out_has_entry),
    .out_moved_key   (out_moved_key),
    .out_result_page (out_result_page),
    .out_middle_key  (out_middle_key),
    .out_entry_count (out_entry_count),
    .out_last        (m_tlast)
  );

  assign s_tready = cmd.in_ready;
  assign m_tuser  = {out_has_entry, out_status};
  assign m_tdata  = {1'b0, out_entry_count, out_middle_key, out_result_page, out_moved_key};

endmodule

// ===== design/sinrs_ctrl.sv =====
// Controller state machine of the sorted index node route split unit.
// Depends on sinrs_pkg for state, command and status types.
`timescale 1ns / 1ps

module sinrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sinrs_pkg::sts_t    sts,
  output sinrs_pkg::cmd_t    cmd
);

  sinrs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sinrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sinrs_pkg::ST_IDLE: begin
        if (in_valid) state_next = sinrs_pkg::ST_DISPATCH;
      end
      sinrs_pkg::ST_DISPATCH: begin
        case (sts.act)
          sinrs_pkg::ACT_INSERT: begin
            state_next = sts.full ? sinrs_pkg::ST_EMIT_FULL : sinrs_pkg::ST_INS_CHK;
          end
          sinrs_pkg::ACT_SPLIT: begin
            state_next = sts.count_max ? sinrs_pkg::ST_SPL_SETUP : sinrs_pkg::ST_INS_CHK;
          end
          sinrs_pkg::ACT_LOCATE: state_next = sinrs_pkg::ST_LOC_CHK;
          default:               state_next = sinrs_pkg::ST_EMIT_OK;
        endcase
      end
      sinrs_pkg::ST_INS_CHK: begin
        if (sts.pos_zero) begin
          state_next = (sts.act == sinrs_pkg::ACT_INSERT) ? sinrs_pkg::ST_EMIT_OK
                                                          : sinrs_pkg::ST_SPL_SETUP;
        end else begin
          state_next = sinrs_pkg::ST_INS_CMP;
        end
      end
      sinrs_pkg::ST_INS_CMP: begin
        if (sts.key_less) begin
          state_next = sinrs_pkg::ST_INS_CHK;
        end else begin
          state_next = (sts.act == sinrs_pkg::ACT_INSERT) ? sinrs_pkg::ST_EMIT_OK
                                                          : sinrs_pkg::ST_SPL_SETUP;
        end
      end
      sinrs_pkg::ST_SPL_SETUP: begin
        state_next = sts.count_zero ? sinrs_pkg::ST_EMIT_MID : sinrs_pkg::ST_SPL_MRD;
      end
      sinrs_pkg::ST_SPL_MRD: state_next = sinrs_pkg::ST_SPL_MTAKE;
      sinrs_pkg::ST_SPL_MTAKE: begin
        state_next = sts.mid_last ? sinrs_pkg::ST_EMIT_MID : sinrs_pkg::ST_SPL_RD;
      end
      sinrs_pkg::ST_SPL_RD: state_next = sinrs_pkg::ST_SPL_EMIT;
      sinrs_pkg::ST_SPL_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.emit_last ? sinrs_pkg::ST_IDLE : sinrs_pkg::ST_SPL_RD;
        end
      end
      sinrs_pkg::ST_LOC_CHK: begin
        state_next = sts.pos_ge_count ? sinrs_pkg::ST_LOC_END : sinrs_pkg::ST_LOC_CMP;
      end
      sinrs_pkg::ST_LOC_CMP: begin
        if (!sts.rd_ge) begin
          state_next = sinrs_pkg::ST_LOC_CHK;
        end else if (sts.out_free) begin
          state_next = sinrs_pkg::ST_IDLE;
        end
      end
      sinrs_pkg::ST_LOC_END,
      sinrs_pkg::ST_EMIT_OK,
      sinrs_pkg::ST_EMIT_FULL,
      sinrs_pkg::ST_EMIT_MID: begin
        if (sts.out_free) state_next = sinrs_pkg::ST_IDLE;
      end
      default: state_next = sinrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel   = sinrs_pkg::RD_POS;
    cmd.out_kind = sinrs_pkg::OUT_OK;
    case (state)
      sinrs_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.latch_in = in_valid;
      end
      sinrs_pkg::ST_DISPATCH: begin
        case (sts.act)
          sinrs_pkg::ACT_INSERT: cmd.pos_count = !sts.full;
          sinrs_pkg::ACT_SPLIT:  cmd.pos_count = !sts.count_max;
          sinrs_pkg::ACT_LOCATE: cmd.pos_clear = 1'b1;
          default:               cmd.set_root  = 1'b1;
        endcase
      end
      sinrs_pkg::ST_INS_CHK: begin
        if (sts.pos_zero) begin
          cmd.wr_new = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sinrs_pkg::RD_POS_M1;
        end
      end
      sinrs_pkg::ST_INS_CMP: begin
        if (sts.key_less) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
        end else begin
          cmd.wr_new = 1'b1;
        end
      end
      sinrs_pkg::ST_SPL_SETUP: cmd.split_setup = 1'b1;
      sinrs_pkg::ST_SPL_MRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sinrs_pkg::RD_MID;
      end
      sinrs_pkg::ST_SPL_MTAKE: cmd.take_mid = 1'b1;
      sinrs_pkg::ST_SPL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sinrs_pkg::RD_POS;
      end
      sinrs_pkg::ST_SPL_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.pos_inc  = sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_ENTRY;
      end
      sinrs_pkg::ST_LOC_CHK: begin
        cmd.rd_en  = !sts.pos_ge_count;
        cmd.rd_sel = sinrs_pkg::RD_POS;
      end
      sinrs_pkg::ST_LOC_CMP: begin
        cmd.pos_inc  = !sts.rd_ge;
        cmd.out_load = sts.rd_ge && sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_HIT;
      end
      sinrs_pkg::ST_LOC_END: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_END;
      end
      sinrs_pkg::ST_EMIT_OK: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_OK;
      end
      sinrs_pkg::ST_EMIT_FULL: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_FULL;
      end
      sinrs_pkg::ST_EMIT_MID: begin
        cmd.out_load = sts.out_free;
        cmd.out_kind = sinrs_pkg::OUT_MID;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/sinrs_dp.sv =====
// Datapath of the sorted index node route split unit: entry memory,
// count, end page, scan position and the output register. Depends on sinrs_pkg.
`timescale 1ns / 1ps

module sinrs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  sinrs_pkg::cmd_t                   cmd,
  output sinrs_pkg::sts_t                   sts,
  input  logic [sinrs_pkg::ACT_W-1:0]       in_action,
  input  logic signed [sinrs_pkg::KEY_W-1:0] in_key,
  input  logic signed [sinrs_pkg::KEY_W-1:0] in_page,
  input  logic signed [sinrs_pkg::KEY_W-1:0] in_right_page,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_status,
  output logic                              out_has_entry,
  output logic signed [sinrs_pkg::KEY_W-1:0] out_moved_key,
  output logic signed [sinrs_pkg::KEY_W-1:0] out_result_page,
  output logic signed [sinrs_pkg::KEY_W-1:0] out_middle_key,
  output logic [sinrs_pkg::CNT_W-1:0]       out_entry_count,
  output logic                              out_last
);

  localparam int KW = sinrs_pkg::KEY_W;
  localparam int CW = sinrs_pkg::CNT_W;
  localparam int IW = sinrs_pkg::IDX_W;

  // Entry memory, page in the upper half and key in the lower half.
  logic [2*KW-1:0] mem [sinrs_pkg::MAX_ENTRIES];
  logic [2*KW-1:0] rdata;
  logic [IW-1:0]   raddr;
  logic [IW-1:0]   waddr;
  logic [2*KW-1:0] wdata;
  logic            wen;

  sinrs_pkg::act_t        act;
  logic signed [KW-1:0]   key;
  logic signed [KW-1:0]   page;
  logic signed [KW-1:0]   right_page;
  logic [CW-1:0]          count;
  logic signed [KW-1:0]   end_page;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          total;
  logic [IW-1:0]          mid;
  logic signed [KW-1:0]   midkey;

  logic signed [KW-1:0]   rd_key;
  logic signed [KW-1:0]   rd_page;
  logic [CW-1:0]          pos_m1;
  logic [CW-1:0]          pos_p1;
  logic [CW-1:0]          mid_p1;

  assign rd_key  = rdata[KW-1:0];
  assign rd_page = rdata[2*KW-1:KW];
  assign pos_m1  = pos - CW'(1);
  assign pos_p1  = pos + CW'(1);
  assign mid_p1  = {1'b0, mid} + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      sinrs_pkg::RD_POS_M1: raddr = pos_m1[IW-1:0];
      sinrs_pkg::RD_MID:    raddr = mid;
      default:              raddr = pos[IW-1:0];
    endcase
  end

  assign wen   = cmd.wr_shift || cmd.wr_new || cmd.set_root;
  assign waddr = cmd.set_root ? '0 : pos[IW-1:0];
  assign wdata = cmd.wr_shift ? rdata : {page, key};

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  // Input latch and working registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act        <= sinrs_pkg::act_t'(in_action);
      key        <= in_key;
      page       <= in_page;
      right_page <= in_right_page;
    end
    if (cmd.pos_count) pos <= count;
    else if (cmd.pos_clear) pos <= '0;
    else if (cmd.pos_dec) pos <= pos_m1;
    else if (cmd.pos_inc) pos <= pos_p1;
    else if (cmd.take_mid) pos <= mid_p1;
    if (cmd.split_setup) begin
      total  <= count;
      mid    <= IW'((count - CW'(1)) >> 1);
      midkey <= '0;
    end
    if (cmd.take_mid) midkey <= rd_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      end_page <= '0;
    end else begin
      if (cmd.set_root) begin
        count    <= CW'(1);
        end_page <= right_page;
      end else if (cmd.wr_new) begin
        count <= count + CW'(1);
      end else if (cmd.take_mid) begin
        count <= mid_p1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status      <= 1'b0;
      out_has_entry   <= 1'b0;
      out_moved_key   <= '0;
      out_result_page <= '0;
      out_middle_key  <= '0;
      out_entry_count <= count;
      out_last        <= 1'b1;
      case (cmd.out_kind)
        sinrs_pkg::OUT_FULL: out_status      <= 1'b1;
        sinrs_pkg::OUT_MID:  out_middle_key  <= midkey;
        sinrs_pkg::OUT_END:  out_result_page <= end_page;
        sinrs_pkg::OUT_HIT:  out_result_page <= rd_page;
        sinrs_pkg::OUT_ENTRY: begin
          out_has_entry   <= 1'b1;
          out_moved_key   <= rd_key;
          out_result_page <= rd_page;
          out_middle_key  <= midkey;
          out_last        <= (pos_p1 == total);
        end
        default: out_status <= 1'b0;
      endcase
    end
  end

  always_comb begin
    sts.act          = act;
    sts.pos_zero     = (pos == '0);
    sts.key_less     = (key < rd_key);
    sts.rd_ge        = !(rd_key < key);
    sts.pos_ge_count = (pos >= count);
    sts.full         = (count > sinrs_pkg::CNT_FULL);
    sts.count_max    = (count >= sinrs_pkg::CNT_MAX);
    sts.count_zero   = (count == '0);
    sts.mid_last     = (mid_p1 >= total);
    sts.emit_last    = (pos_p1 == total);
    sts.out_free     = !out_valid || out_ready;
  end

  assert property (@(posedge clk) disable iff (rst) count <= sinrs_pkg::CNT_MAX)
    else $error("Entry count exceeds node capacity.");

  assert property (@(posedge clk) disable iff (rst)
                   cmd.wr_new |-> count < sinrs_pkg::CNT_MAX)
    else $error("New pair written into a node with no room.");

  assert property (@(posedge clk) disable iff (rst)
                   cmd.out_load |-> (!out_valid || out_ready))
    else $error("Output register overwritten while a transfer is pending.");

  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Output valid set right after reset.");

endmodule

// ===== bench/sorted_index_node_route_split_unit_tb.sv =====
// Testbench for the sorted index node route split unit.
// Drives insert, split, locate and root actions and checks every result transfer against
// an in-bench model of the node; depends on sinrs_pkg and the unit's RTL.
`timescale 1ns / 1ps

module sorted_index_node_route_split_unit_tb;

  // One input item: action plus the three packed data fields.
  typedef struct packed {
    sinrs_pkg::act_t act;
    logic [31:0]     key;
    logic [31:0]     page;
    logic [31:0]     right_page;
  } node_cmd_t;

  // One result transfer as it appears on the output stream.
  typedef struct packed {
    logic        status;
    logic        has_entry;
    logic [31:0] moved_key;
    logic [31:0] result_page;
    logic [31:0] middle_key;
    logic [6:0]  entry_count;
    logic        last;
  } node_resp_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  sorted_index_node_route_split_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the node that predicts every result.
  logic signed [31:0] shadow_keys [sinrs_pkg::MAX_ENTRIES];
  logic [31:0]        shadow_pages [sinrs_pkg::MAX_ENTRIES];
  int                 shadow_count;
  logic [31:0]        shadow_end;

  node_cmd_t  pending_cmds [$];
  node_resp_t expected_resps [$];
  int         error_count;
  int         resp_total;
  int         split_total;
  int         full_total;
  bit         calm_tail;   // no idling on either side near the end
  bit         stim_done;
  int         send_gap;
  int         recv_gap;

  // Sorted insert that lands after every equal key; caller guarantees room.
  function automatic void shadow_place(logic signed [31:0] k, logic [31:0] p);
    int pos;
    pos = shadow_count;
    while (pos > 0 && k < shadow_keys[pos-1]) begin
      shadow_keys[pos]  = shadow_keys[pos-1];
      shadow_pages[pos] = shadow_pages[pos-1];
      pos--;
    end
    shadow_keys[pos]  = k;
    shadow_pages[pos] = p;
    shadow_count++;
  endfunction

  function automatic node_resp_t make_resp(logic st, logic he, logic [31:0] mk,
                                           logic [31:0] pg, logic [31:0] mid, logic lst);
    node_resp_t r;
    r.status      = st;
    r.has_entry   = he;
    r.moved_key   = mk;
    r.result_page = pg;
    r.middle_key  = mid;
    r.entry_count = 7'(shadow_count);
    r.last        = lst;
    return r;
  endfunction

  // Apply one accepted item to the shadow node and queue what it should produce.
  function automatic void predict_node_step(node_cmd_t c);
    int total;
    int mid;
    logic [31:0] midkey;
    logic [31:0] found;
    case (c.act)
      sinrs_pkg::ACT_INSERT: begin
        if (shadow_count + 2 > sinrs_pkg::MAX_ENTRIES) begin
          expected_resps.push_back(make_resp(1'b1, 1'b0, '0, '0, '0, 1'b1));
        end else begin
          shadow_place(c.key, c.page);
          expected_resps.push_back(make_resp(1'b0, 1'b0, '0, '0, '0, 1'b1));
        end
      end
      sinrs_pkg::ACT_SPLIT: begin
        if (shadow_count < sinrs_pkg::MAX_ENTRIES) shadow_place(c.key, c.page);
        total = shadow_count;
        mid = (total - 1) / 2;
        midkey = shadow_keys[mid];
        shadow_count = mid + 1;
        if (mid + 1 >= total) begin
          expected_resps.push_back(make_resp(1'b0, 1'b0, '0, '0, midkey, 1'b1));
        end else begin
          for (int i = mid + 1; i < total; i++)
            expected_resps.push_back(make_resp(1'b0, 1'b1, shadow_keys[i],
                                               shadow_pages[i], midkey, i + 1 == total));
        end
      end
      sinrs_pkg::ACT_LOCATE: begin
        found = shadow_end;
        for (int i = 0; i < shadow_count; i++) begin
          if (!(shadow_keys[i] < $signed(c.key))) begin
            found = shadow_pages[i];
            break;
          end
        end
        expected_resps.push_back(make_resp(1'b0, 1'b0, '0, found, '0, 1'b1));
      end
      default: begin
        shadow_keys[0]  = c.key;
        shadow_pages[0] = c.page;
        shadow_end      = c.right_page;
        shadow_count    = 1;
        expected_resps.push_back(make_resp(1'b0, 1'b0, '0, '0, '0, 1'b1));
      end
    endcase
  endfunction

  // Driver: feeds pending items, inserting random idle bursts. While drain_req
  // is set no new item is offered.
  bit drain_req;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_node_step(pending_cmds.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the current item
      end else if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0 && !drain_req) begin
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
          s_tvalid <= 1'b0;
          send_gap <= $urandom_range(0, 5);
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= {pending_cmds[0].right_page, pending_cmds[0].page, pending_cmds[0].key};
          s_tuser  <= pending_cmds[0].act;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: applies receiver stalls and checks each result transfer in order.
  always @(posedge clk) begin
    node_resp_t got;
    node_resp_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.moved_key   = m_tdata[31:0];
        got.result_page = m_tdata[63:32];
        got.middle_key  = m_tdata[95:64];
        got.entry_count = m_tdata[102:96];
        got.status      = m_tuser[0];
        got.has_entry   = m_tuser[1];
        got.last        = m_tlast;
        resp_total++;
        if (expected_resps.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (got.has_entry) split_total++;
          if (got.status) full_total++;
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            error_count++;
          end
          if (got.has_entry !== exp_r.has_entry) begin
            $error("has_entry: expected %0d, got %0d", exp_r.has_entry, got.has_entry);
            error_count++;
          end
          if (got.moved_key !== exp_r.moved_key) begin
            $error("moved_key: expected %h, got %h", exp_r.moved_key, got.moved_key);
            error_count++;
          end
          if (got.result_page !== exp_r.result_page) begin
            $error("result_page: expected %h, got %h", exp_r.result_page, got.result_page);
            error_count++;
          end
          if (got.middle_key !== exp_r.middle_key) begin
            $error("middle_key: expected %h, got %h", exp_r.middle_key, got.middle_key);
            error_count++;
          end
          if (got.entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, got.entry_count);
            error_count++;
          end
          if (got.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        recv_gap <= $urandom_range(0, 5);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic node_cmd_t mk_cmd(sinrs_pkg::act_t a, logic [31:0] k, logic [31:0] p,
                                       logic [31:0] rp);
    node_cmd_t c;
    c.act = a;
    c.key = k;
    c.page = p;
    c.right_page = rp;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'($urandom_range(0, 15)) - 32'd8;   // small keys give many ties
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: the item counter tracks only the phase; the drain pause lives here.
  initial begin
    int fill;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    shadow_count = 0;
    shadow_end = '0;
    error_count = 0;
    resp_total = 0;
    split_total = 0;
    full_total = 0;
    calm_tail = 1'b0;
    stim_done = 1'b0;
    drain_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-node locate, splits, extremes, equal keys, full node.
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h0, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, 32'h7fff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, 32'h5, 32'h11, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, 32'h5, 32'h22, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h5, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h8000_0000, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h7fff_ffff, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_SPLIT, 32'h0, 32'h33, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_ROOT, 32'h7fff_ffff, 32'h1234, 32'hffff_ffff));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h8000_0000, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, 32'h7fff_ffff, 32'h0, 32'h0));
    // A split moves nothing only on an empty node, which only reset gives; a root then
    // split of two moves one entry instead.
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_SPLIT, 32'h8000_0000, 32'h0, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_SPLIT, 32'h8000_0000, 32'h1, 32'h0));
    // Fill to the full limit, then try inserts, and split so that its insert fills every slot.
    for (fill = 0; fill < sinrs_pkg::MAX_ENTRIES + 2; fill++)
      pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, rand_word(), $urandom, 32'h0));
    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_SPLIT, rand_word(), $urandom, 32'h0));
    wait (pending_cmds.size() == 0);

    // Pause until every expected result has come back.
    drain_req = 1'b1;
    wait (expected_resps.size() == 0 && !s_tvalid);
    drain_req = 1'b0;

    // Random: inserts and locates in equal share, with fewer splits and roots.
    for (int n = 0; n < 40; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_INSERT, rand_word(),
                                                  $urandom, $urandom));
        4:          pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_SPLIT, rand_word(),
                                                  $urandom, $urandom));
        5, 6, 7, 8: pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_LOCATE, rand_word(),
                                                  $urandom, $urandom));
        default:    pending_cmds.push_back(mk_cmd(sinrs_pkg::ACT_ROOT, rand_word(),
                                                  $urandom, $urandom));
      endcase
      if (n == 32) begin
        wait (pending_cmds.size() < 4);
        calm_tail = 1'b1;
      end
    end
    wait (pending_cmds.size() == 0 && !s_tvalid);
    wait (expected_resps.size() == 0);
    repeat (300) @(posedge clk);
    stim_done = 1'b1;
    $display("Covered %0d result transfers, %0d moved split entries, %0d full refusals.",
             resp_total, split_total, full_total);
    if (error_count == 0 && expected_resps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
